// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the neuron core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define ASSERT_SAME(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/xpn_pkg.sv =====
// Package with widths, constants, types, and the accumulator-width and popcount functions of the neuron core.
package xpn_pkg;

   localparam int MAX_WORDS_DEFAULT = 64;
   localparam int WORD_W = 64;
   localparam int HALF_W = 32;
   localparam int BIAS_W = 16;
   localparam int SCALE_W = 16;
   localparam int VALUE_W = 29;
   localparam int COUNT_W = 7;
   localparam int DELTA_W = 8;
   localparam int CALC_W = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NARROW = 1'b1;

   localparam logic signed [SCALE_W-1:0] SCALE_RESET = 16'sd256;

   localparam logic [WORD_W-1:0] POP_M1 = 64'h5555555555555555;
   localparam logic [WORD_W-1:0] POP_M2 = 64'h3333333333333333;
   localparam logic [WORD_W-1:0] POP_M4 = 64'h0F0F0F0F0F0F0F0F;

   typedef struct packed {
      logic advance;
      logic last;
   } acc_ctl_type;

   function automatic int acc_width(input int max_words);
      return $clog2(max_words * WORD_W + 1) + 1;
   endfunction

   function automatic logic [COUNT_W-1:0] count_ones(input logic [WORD_W-1:0] value);
      logic [WORD_W-1:0] v;
      v = value - ((value >> 1) & POP_M1);
      v = (v & POP_M2) + ((v >> 2) & POP_M2);
      v = (v + (v >> 4)) & POP_M4;
      v = v + (v >> 8);
      v = v + (v >> 16);
      v = v + (v >> 32);
      return v[COUNT_W-1:0];
   endfunction

endpackage

// ===== rtl/core/xpn_if.sv =====
// Valid/ready channel interfaces for the input words and the neuron results.
interface xpn_req_if;
   logic                                valid;
   logic                                ready;
   logic [xpn_pkg::WORD_W-1:0]          activation_word;
   logic [xpn_pkg::WORD_W-1:0]          weight_word;
   logic signed [xpn_pkg::BIAS_W-1:0]   bias_value;
   logic                                last_word;

   modport source (output valid, output activation_word, output weight_word,
                   output bias_value, output last_word, input ready);
   modport sink (input valid, input activation_word, input weight_word,
                 input bias_value, input last_word, output ready);
endinterface

interface xpn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [xpn_pkg::VALUE_W-1:0]  neuron_value;
   logic                                neuron_bit;

   modport source (output valid, output neuron_value, output neuron_bit, input ready);
   modport sink (input valid, input neuron_value, input neuron_bit, output ready);
endinterface

// ===== rtl/core/xpn_delta.sv =====
// Matches-minus-mismatches count of one activation word against one weight word.
module xpn_delta (
   input  logic [xpn_pkg::WORD_W-1:0]         activation,
   input  logic [xpn_pkg::WORD_W-1:0]         weight,
   input  logic                               narrow,
   output logic signed [xpn_pkg::DELTA_W-1:0] delta
);

   logic [xpn_pkg::WORD_W-1:0]  same;
   logic [xpn_pkg::COUNT_W-1:0] count;
   logic [xpn_pkg::DELTA_W-1:0] bits;

   always_comb begin
      same = ~(activation ^ weight);
      if (narrow) begin
         same = {{(xpn_pkg::WORD_W - xpn_pkg::HALF_W){1'b0}},
                 same[xpn_pkg::HALF_W-1:0]};
      end
   end

   assign count = xpn_pkg::count_ones(same);
   assign bits = narrow ? xpn_pkg::DELTA_W'(xpn_pkg::HALF_W)
                        : xpn_pkg::DELTA_W'(xpn_pkg::WORD_W);
   assign delta = $signed({count, 1'b0} - bits);

endmodule

// ===== rtl/core/xpn_accum.sv =====
// Saturating match-sum accumulator and the register that holds a finished sum.
module xpn_accum #(
   parameter int MAX_WORDS = xpn_pkg::MAX_WORDS_DEFAULT,
   parameter int ACC_W = xpn_pkg::acc_width(MAX_WORDS)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  xpn_pkg::acc_ctl_type               ctl,
   input  logic signed [xpn_pkg::DELTA_W-1:0] delta,
   input  logic signed [xpn_pkg::BIAS_W-1:0]  bias_in,
   output logic signed [ACC_W-1:0]            acc_value,
   output logic signed [ACC_W-1:0]            final_sum,
   output logic signed [xpn_pkg::BIAS_W-1:0]  final_bias
);

   localparam int LIMIT = MAX_WORDS * xpn_pkg::WORD_W;
   localparam logic signed [ACC_W:0] LIMIT_POS = (ACC_W + 1)'(LIMIT);
   localparam logic signed [ACC_W:0] LIMIT_NEG = -LIMIT_POS;

   logic signed [ACC_W-1:0]           acc_ff;
   logic signed [ACC_W-1:0]           acc_in;
   logic signed [ACC_W-1:0]           sum_ff;
   logic signed [xpn_pkg::BIAS_W-1:0] bias_ff;
   logic signed [ACC_W:0]             sum_wide;
   logic signed [ACC_W:0]             clamped;

   always_comb begin
      sum_wide = $signed({acc_ff[ACC_W-1], acc_ff})
               + $signed({{(ACC_W + 1 - xpn_pkg::DELTA_W){delta[xpn_pkg::DELTA_W-1]}}, delta});
      if (sum_wide > LIMIT_POS) begin
         clamped = LIMIT_POS;
      end else if (sum_wide < LIMIT_NEG) begin
         clamped = LIMIT_NEG;
      end else begin
         clamped = sum_wide;
      end
      acc_in = acc_ff;
      if (ctl.advance) begin
         acc_in = ctl.last ? '0 : clamped[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance && ctl.last) begin
         sum_ff <= clamped[ACC_W-1:0];
         bias_ff <= bias_in;
      end
   end

   assign acc_value = acc_ff;
   assign final_sum = sum_ff;
   assign final_bias = bias_ff;

endmodule

// ===== rtl/core/xpn_scale.sv =====
// Output register that holds the scaled and biased neuron value and a bit set when it is not negative.
module xpn_scale #(
   parameter int ACC_W = xpn_pkg::acc_width(xpn_pkg::MAX_WORDS_DEFAULT)
) (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [ACC_W-1:0]             sum,
   input  logic signed [xpn_pkg::BIAS_W-1:0]   bias,
   input  logic signed [xpn_pkg::SCALE_W-1:0]  scale,
   output logic signed [xpn_pkg::VALUE_W-1:0]  value,
   output logic                                value_bit
);

   localparam int PROD_W = ACC_W + xpn_pkg::SCALE_W;

   logic signed [PROD_W-1:0]           product;
   logic signed [xpn_pkg::CALC_W-1:0]  total;
   logic signed [xpn_pkg::VALUE_W-1:0] value_ff;
   logic                               bit_ff;

   assign product = sum * scale;
   assign total = $signed({{(xpn_pkg::CALC_W - PROD_W){product[PROD_W-1]}}, product})
                + $signed({{(xpn_pkg::CALC_W - xpn_pkg::BIAS_W){bias[xpn_pkg::BIAS_W-1]}},
                           bias});

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= total[xpn_pkg::VALUE_W-1:0];
         bit_ff <= ~total[xpn_pkg::CALC_W-1];
      end
   end

   assign value = value_ff;
   assign value_bit = bit_ff;

endmodule

// ===== rtl/core/xnor_popcount_neuron_core.sv =====
// Binarized neuron: XNOR-popcount accumulation over words, then scale, bias and sign.
// The core takes one activation/weight word per clock cycle when the result side is
// not stalled. A word passes an input register, a popcount register, the accumulator
// and the output register; only a word marked last yields a result. The one-cycle
// rate is set by the accumulator's add and saturate loop, which closes on itself
// every cycle. The match sum saturates at plus or minus MAX_WORDS*64, and it clears
// after every last word. Scale and the 32-bit word mode must be written through the
// csr port only while no word is in flight; the core itself does not enforce this.
`include "assert_macros.svh"

module xnor_popcount_neuron_core #(
   parameter int MAX_WORDS = xpn_pkg::MAX_WORDS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   xpn_req_if.sink                              req_ch,
   xpn_rsp_if.source                            rsp_ch,
   input  logic                                 csr_write_en,
   input  logic [xpn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [xpn_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int ACC_W = xpn_pkg::acc_width(MAX_WORDS);
   localparam logic signed [ACC_W-1:0] ACC_LIMIT = ACC_W'(MAX_WORDS * xpn_pkg::WORD_W);

   logic signed [xpn_pkg::SCALE_W-1:0] scale_ff;
   logic                               narrow_ff;

   logic                               v1_ff, v1_in;
   logic                               v2_ff, v2_in;
   logic                               v3_ff, v3_in;
   logic                               vo_ff, vo_in;

   logic [xpn_pkg::WORD_W-1:0]         act1_ff;
   logic [xpn_pkg::WORD_W-1:0]         wgt1_ff;
   logic signed [xpn_pkg::BIAS_W-1:0]  bias1_ff;
   logic                               last1_ff;

   logic signed [xpn_pkg::DELTA_W-1:0] delta;
   logic signed [xpn_pkg::DELTA_W-1:0] delta2_ff;
   logic signed [xpn_pkg::BIAS_W-1:0]  bias2_ff;
   logic                               last2_ff;

   logic                               out_free, adv3, s3_free, adv2, s2_free, adv1, accept;
   xpn_pkg::acc_ctl_type               acc_ctl;
   logic signed [ACC_W-1:0]            acc_value;
   logic signed [ACC_W-1:0]            final_sum;
   logic signed [xpn_pkg::BIAS_W-1:0]  final_bias;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= xpn_pkg::SCALE_RESET;
         narrow_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            xpn_pkg::CSR_SCALE: begin
               scale_ff <= $signed(csr_write_data[xpn_pkg::SCALE_W-1:0]);
            end
            xpn_pkg::CSR_NARROW: begin
               narrow_ff <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign out_free = !vo_ff || rsp_ch.ready;
   assign adv3 = v3_ff && out_free;
   assign s3_free = !v3_ff || out_free;
   assign adv2 = v2_ff && s3_free;
   assign s2_free = !v2_ff || s3_free;
   assign adv1 = v1_ff && s2_free;
   assign req_ch.ready = !v1_ff || s2_free;
   assign accept = req_ch.valid && req_ch.ready;

   assign v1_in = accept ? 1'b1 : (adv1 ? 1'b0 : v1_ff);
   assign v2_in = adv1 ? 1'b1 : (adv2 ? 1'b0 : v2_ff);
   assign v3_in = (adv2 && last2_ff) ? 1'b1 : (adv3 ? 1'b0 : v3_ff);
   assign vo_in = adv3 ? 1'b1 : (rsp_ch.ready ? 1'b0 : vo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act1_ff <= req_ch.activation_word;
         wgt1_ff <= req_ch.weight_word;
         bias1_ff <= req_ch.bias_value;
         last1_ff <= req_ch.last_word;
      end
   end

   xpn_delta u_delta (
      .activation (act1_ff),
      .weight     (wgt1_ff),
      .narrow     (narrow_ff),
      .delta      (delta)
   );

   always_ff @(posedge clock) begin
      if (adv1) begin
         delta2_ff <= delta;
         bias2_ff <= bias1_ff;
         last2_ff <= last1_ff;
      end
   end

   assign acc_ctl.advance = adv2;
   assign acc_ctl.last = last2_ff;

   xpn_accum #(
      .MAX_WORDS (MAX_WORDS),
      .ACC_W     (ACC_W)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .ctl        (acc_ctl),
      .delta      (delta2_ff),
      .bias_in    (bias2_ff),
      .acc_value  (acc_value),
      .final_sum  (final_sum),
      .final_bias (final_bias)
   );

   xpn_scale #(
      .ACC_W (ACC_W)
   ) u_scale (
      .clock     (clock),
      .load      (adv3),
      .sum       (final_sum),
      .bias      (final_bias),
      .scale     (scale_ff),
      .value     (rsp_ch.neuron_value),
      .value_bit (rsp_ch.neuron_bit)
   );

   assign rsp_ch.valid = vo_ff;

   `ASSERT_ALWAYS(a_acc_bound, clock, reset, (acc_value <= ACC_LIMIT) && (acc_value >= -ACC_LIMIT), "Match sum left its saturation range.")
   `ASSERT_NEXT(a_acc_clear, clock, reset, adv2 && last2_ff, acc_value == '0, "Match sum not cleared after a last word.")
   `ASSERT_SAME(a_bit_sign, clock, reset, rsp_ch.valid, rsp_ch.neuron_bit == !rsp_ch.neuron_value[xpn_pkg::VALUE_W-1], "Neuron bit disagrees with the sign of the value.")
   `ASSERT_NEXT(a_result_load, clock, reset, adv3, rsp_ch.valid, "A finished sum did not reach the output register.")

endmodule

// ===== bench/xnor_popcount_neuron_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts the neuron results from the accepted words and compares each result.
module xnor_popcount_neuron_checker #(
   parameter int MAX_WORDS = xpn_pkg::MAX_WORDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   xpn_req_if                              req_ch,
   xpn_rsp_if                              rsp_ch,
   input  logic                            csr_write_en,
   input  logic [xpn_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [xpn_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                              fail_count,
   output int                              pending_count
);

   localparam int SUM_CAP = MAX_WORDS * xpn_pkg::WORD_W;

   typedef struct packed {
      logic signed [xpn_pkg::VALUE_W-1:0] neuron_value;
      logic                               neuron_bit;
   } neuron_result_type;

   neuron_result_type                   expected_neurons[$];
   int                                  match_sum;
   logic signed [xpn_pkg::SCALE_W-1:0]  scale_q;
   logic                                narrow_q;

   initial begin
      fail_count = 0;
      pending_count = 0;
      match_sum = 0;
      scale_q = xpn_pkg::SCALE_RESET;
      narrow_q = 1'b0;
   end

   function automatic void note_failure();
      fail_count = fail_count + 1;
   endfunction

   function automatic void accumulate_word(input logic [xpn_pkg::WORD_W-1:0] activation,
                                           input logic [xpn_pkg::WORD_W-1:0] weight,
                                           input logic signed [xpn_pkg::BIAS_W-1:0] bias,
                                           input logic last);
      logic [xpn_pkg::WORD_W-1:0] agree;
      int                         delta;
      longint                     total;
      neuron_result_type          result;
      agree = ~(activation ^ weight);
      if (narrow_q) begin
         delta = 2 * $countones(agree[xpn_pkg::HALF_W-1:0]) - xpn_pkg::HALF_W;
      end else begin
         delta = 2 * $countones(agree) - xpn_pkg::WORD_W;
      end
      match_sum = match_sum + delta;
      if (match_sum > SUM_CAP) match_sum = SUM_CAP;
      if (match_sum < -SUM_CAP) match_sum = -SUM_CAP;
      if (last) begin
         total = longint'(match_sum) * longint'(scale_q) + longint'(bias);
         result.neuron_value = total[xpn_pkg::VALUE_W-1:0];
         result.neuron_bit = (total >= 0);
         expected_neurons.push_back(result);
         match_sum = 0;
      end
   endfunction

   always @(posedge clock) begin : watch
      neuron_result_type want;
      if (reset) begin
         match_sum = 0;
         scale_q = xpn_pkg::SCALE_RESET;
         narrow_q = 1'b0;
         expected_neurons.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_neurons.size() == 0) begin
               note_failure();
               $display("%0t: unexpected result, value %0d bit %0b", $time,
                        rsp_ch.neuron_value, rsp_ch.neuron_bit);
            end else begin
               want = expected_neurons.pop_front();
               if (rsp_ch.neuron_value !== want.neuron_value) begin
                  note_failure();
                  $display("%0t: neuron_value expected %0d, actual %0d", $time,
                           want.neuron_value, rsp_ch.neuron_value);
               end
               if (rsp_ch.neuron_bit !== want.neuron_bit) begin
                  note_failure();
                  $display("%0t: neuron_bit expected %0b, actual %0b", $time,
                           want.neuron_bit, rsp_ch.neuron_bit);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            accumulate_word(req_ch.activation_word, req_ch.weight_word,
                            req_ch.bias_value, req_ch.last_word);
         if (csr_write_en) begin
            case (csr_index)
               xpn_pkg::CSR_SCALE: scale_q = csr_write_data;
               xpn_pkg::CSR_NARROW: narrow_q = csr_write_data[0];
               default: ;
            endcase
         end
      end
      pending_count <= expected_neurons.size();
   end

endmodule

// ===== bench/xnor_popcount_neuron_core_test.sv =====
`timescale 1ns / 100ps
// Top of the neuron core testbench: clock, reset, word stimulus, register phases and verdict.
module xnor_popcount_neuron_core_test;

   typedef enum int {WORD_RANDOM, WORD_NEAR_MATCH, WORD_NEAR_OPPOSE, WORD_EQUAL,
                     WORD_INVERSE} word_mix_type;

   localparam int PHASES = 11;
   localparam int WORDS_PER_PHASE = 155;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 8;

   logic                             clock;
   logic                             reset;
   logic                             csr_write_en;
   logic [xpn_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [xpn_pkg::CSR_DATA_W-1:0]   csr_write_data;
   int                               fail_count;
   int                               pending_count;
   int                               words_sent;
   int                               send_idle_pct;
   int                               ready_stall_pct;
   int                               holds_asked;
   logic                             narrow_now;

   xpn_req_if req_ch();
   xpn_rsp_if rsp_ch();

   xnor_popcount_neuron_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   xnor_popcount_neuron_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   // The receiver serves each long hold request by counting its own cycles.
   initial begin : receiver
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            holds_served = holds_served + 1;
            hold_left = LONG_HOLD;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
         end
      end
   end

   function automatic logic [63:0] random_word();
      logic [63:0] word;
      word = {$urandom, $urandom};
      case ($urandom_range(7))
         0: word = word & {$urandom, $urandom};
         1: word = word | {$urandom, $urandom};
         default: ;
      endcase
      return word;
   endfunction

   function automatic logic signed [15:0] random_bias();
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   task automatic send_word(input logic [63:0] activation, input logic [63:0] weight,
                            input logic signed [15:0] bias, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.activation_word <= activation;
      req_ch.weight_word <= weight;
      req_ch.bias_value <= bias;
      req_ch.last_word <= last;
      do @(posedge clock); while (!req_ch.ready);
      words_sent = words_sent + 1;
   endtask

   task automatic send_neuron(input int words, input word_mix_type mix);
      logic [63:0] activation;
      logic [63:0] weight;
      logic [63:0] flips;
      for (int i = 0; i < words; i++) begin
         activation = random_word();
         flips = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         case (mix)
            WORD_NEAR_MATCH: weight = activation ^ flips;
            WORD_NEAR_OPPOSE: weight = ~activation ^ flips;
            WORD_EQUAL: weight = activation;
            WORD_INVERSE: weight = ~activation;
            default: weight = random_word();
         endcase
         send_word(activation, weight, random_bias(), i == words - 1);
      end
   endtask

   task automatic drain_and_settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(input logic [15:0] scale, input logic narrow);
      csr_write_en <= 1'b1;
      csr_index <= xpn_pkg::CSR_SCALE;
      csr_write_data <= scale;
      @(posedge clock);
      csr_index <= xpn_pkg::CSR_NARROW;
      csr_write_data <= {15'($urandom_range(32767)), narrow};
      @(posedge clock);
      csr_write_en <= 1'b0;
      narrow_now = narrow;
   endtask

   initial begin : stimulus
      int idle_modes[4][2];
      logic [15:0] scales[6];
      logic [15:0] scale;
      logic narrow;
      int goal;
      int pick;
      int mode;
      idle_modes = '{'{0, 0}, '{52, 0}, '{0, 52}, '{24, 24}};
      scales = '{16'd256, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF, 16'd1};
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= xpn_pkg::CSR_SCALE;
      csr_write_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.activation_word <= '0;
      req_ch.weight_word <= '0;
      req_ch.bias_value <= '0;
      req_ch.last_word <= 1'b0;
      send_idle_pct = 0;
      ready_stall_pct = 0;
      holds_asked = 0;
      words_sent = 0;
      narrow_now = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_word(64'h0, 64'h0, 16'sh7FFF, 1'b1);
      send_word('1, 64'h0, 16'sh8000, 1'b1);
      send_word('1, '1, 16'sh7FFF, 1'b0);
      send_word(64'h0, '1, 16'sd5, 1'b0);
      send_word(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, -16'sd1, 1'b1);
      send_word(64'h00000000FFFFFFFF, 64'h0, 16'sd0, 1'b1);
      send_word(64'hFFFFFFFF00000000, 64'h0, -16'sd1, 1'b1);
      send_word(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 16'sh1234, 1'b0);
      send_word('1, 64'h0, 16'sh8000, 1'b0);
      send_word('1, 64'h0, 16'sd0, 1'b1);
      for (int i = 0; i < 8; i++)
         send_word(random_word(), random_word(), random_bias(), i[0]);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_and_settle();
         if (phase < 6) begin
            scale = scales[phase];
            narrow = (phase == 2 || phase == 4);
         end else begin
            scale = 16'($urandom_range(65535));
            narrow = 1'($urandom_range(1));
         end
         program_registers(scale, narrow);
         mode = phase % 4;
         send_idle_pct = idle_modes[mode][0];
         ready_stall_pct = idle_modes[mode][1];
         if (phase == 2 || phase == 7) holds_asked = holds_asked + 1;
         goal = words_sent + WORDS_PER_PHASE;
         while (words_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
               send_neuron(narrow_now ? 129 + $urandom_range(3) : 65 + $urandom_range(5),
                           $urandom_range(1) ? WORD_EQUAL : WORD_INVERSE);
            end else if (pick < 20) begin
               send_neuron(9 + $urandom_range(31), word_mix_type'($urandom_range(2)));
            end else begin
               send_neuron(1 + $urandom_range(7), word_mix_type'($urandom_range(2)));
            end
         end
      end

      drain_and_settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== xnor_popcount_neuron_core.f =====
+incdir+rtl/core
rtl/core/xpn_pkg.sv
rtl/core/xpn_if.sv
rtl/core/xpn_delta.sv
rtl/core/xpn_accum.sv
rtl/core/xpn_scale.sv
rtl/core/xnor_popcount_neuron_core.sv
bench/xnor_popcount_neuron_checker.sv
bench/xnor_popcount_neuron_core_test.sv
